// ===== sv/bdlp_pkg.sv =====
// Package for the button debouncer with long-press detection.
// Holds the result type, register indexes, reset values and the counter helper.
// No dependencies.
`default_nettype none

package bdlp_pkg;

    localparam int unsigned CNT_W = 16;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CNT_W-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [CNT_W-1:0] LONG_PRESS_RESET = 16'd1000;

    // Configuration register indexes
    typedef enum logic
    {
        REG_DEBOUNCE_LIMIT   = 1'b0,
        REG_LONG_PRESS_LIMIT = 1'b1
    } cfg_idx_t;

    // Pin levels (active low button)
    localparam logic LVL_PRESSED  = 1'b0;
    localparam logic LVL_RELEASED = 1'b1;

    typedef struct packed
    {
        logic short_press_event;
        logic release_event;
        logic long_press_event;
        logic held_flag;
    } result_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== sv/button_debounce_long_press.sv =====
// Button debouncer with long-press detection: top level.
// One pin sample in, one beat of event flags out; output register plus skid stage.
// Depends on bdlp_pkg.
`default_nettype none

// Channel   | Dir | Handshake             | Payload
// ----------+-----+-----------------------+-------------------------------------------
// input     | in  | in_valid / in_stall   | pin_level
// result    | out | out_valid / out_stall | short_press_event, release_event,
//           |     |                       | long_press_event, held_flag
// config    | in  | cfg_we                | cfg_index, cfg_data
//
// A sample is accepted every cycle while in_stall is low, and its flags are registered
// on the edge that accepts it, in the output register or, if that is stalled, in the skid
// register. The state update is a single pass of two 16-bit saturating increments and
// two 16-bit compares. Reset sets both limits to their defaults, levels to released and
// counters to zero. A stalled output holds its beat; one more result goes to the skid
// register, and in_stall rises only while that skid register is full.

module button_debounce_long_press
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [bdlp_pkg::CNT_W-1:0]  cfg_data,

    input  wire logic                        in_valid,
    output      logic                        in_stall,
    input  wire logic                        pin_level,

    output      logic                        out_valid,
    input  wire logic                        out_stall,
    output      logic                        short_press_event,
    output      logic                        release_event,
    output      logic                        long_press_event,
    output      logic                        held_flag
);
    import bdlp_pkg::*;

    // Configuration
    logic [CNT_W-1:0] debounce_limit_reg;
    logic [CNT_W-1:0] long_press_limit_reg;

    // Debounce state
    logic             last_raw_reg,      last_raw_next;
    logic             stable_level_reg,  stable_level_next;
    logic [CNT_W-1:0] stable_ticks_reg,  stable_ticks_next;
    logic             long_pending_reg,  long_pending_next;
    logic [CNT_W-1:0] hold_ticks_reg,    hold_ticks_next;

    // Output and skid stages
    logic    out_valid_reg,  out_valid_next;
    result_t out_data_reg,   out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg,  skid_data_next;

    logic             in_acc;
    logic             out_take;
    logic             restart;
    logic [CNT_W-1:0] stable_inc;
    logic [CNT_W-1:0] hold_inc;
    logic             adopt;
    logic             adopt_release;
    logic             adopt_press;
    logic             pend_mid;
    logic [CNT_W-1:0] hold_mid;
    result_t          res;

    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    // ---------------- configuration writes ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_limit_reg   <= DEBOUNCE_RESET;
            long_press_limit_reg <= LONG_PRESS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_DEBOUNCE_LIMIT:   debounce_limit_reg   <= cfg_data;
                REG_LONG_PRESS_LIMIT: long_press_limit_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // ---------------- per-sample step ----------------
    always_comb
    begin
        restart       = (pin_level != last_raw_reg);
        stable_inc    = sat_inc(stable_ticks_reg);
        hold_inc      = sat_inc(hold_ticks_reg);

        // new level adopted once stable strictly longer than the limit
        adopt         = !restart && (stable_inc > debounce_limit_reg)
                        && (pin_level != stable_level_reg);
        adopt_release = adopt && (pin_level == LVL_RELEASED);
        adopt_press   = adopt && (pin_level == LVL_PRESSED);

        pend_mid = adopt_release ? 1'b0 : (adopt_press ? 1'b1 : long_pending_reg);
        hold_mid = adopt_press ? '0 : hold_inc;

        stable_level_next = adopt ? pin_level : stable_level_reg;

        res.short_press_event = adopt_release && long_pending_reg;
        res.release_event     = adopt_release;
        res.long_press_event  = !restart && pend_mid && (hold_mid > long_press_limit_reg);
        res.held_flag         = !restart && (stable_level_next == LVL_PRESSED);

        last_raw_next     = pin_level;
        stable_ticks_next = restart ? '0 : stable_inc;
        hold_ticks_next   = hold_mid;
        long_pending_next = res.long_press_event ? 1'b0 : pend_mid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg     <= LVL_RELEASED;
            stable_level_reg <= LVL_RELEASED;
            stable_ticks_reg <= '0;
            long_pending_reg <= 1'b0;
            hold_ticks_reg   <= '0;
        end
        else if (in_acc)
        begin
            last_raw_reg     <= last_raw_next;
            stable_level_reg <= stable_level_next;
            stable_ticks_reg <= stable_ticks_next;
            long_pending_reg <= long_pending_next;
            hold_ticks_reg   <= hold_ticks_next;
        end
    end

    // ---------------- output register and skid ----------------
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (!out_valid_reg || out_take)
        begin
            // output slot frees up: skid drains first (input is stalled then)
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_acc;
                out_data_next  = res;
            end
        end
        else if (in_acc)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid         = out_valid_reg;
    assign short_press_event = out_data_reg.short_press_event;
    assign release_event     = out_data_reg.release_event;
    assign long_press_event  = out_data_reg.long_press_event;
    assign held_flag         = out_data_reg.held_flag;

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid filled without a stalled output");

    a_short_needs_release: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.short_press_event) |-> out_data_reg.release_event)
        else $error("short press flagged without release");

    a_release_not_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.release_event
                            && (out_data_reg.held_flag || out_data_reg.long_press_event)))
        else $error("release flagged together with held or long press");

    a_pending_cleared_on_long: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && res.long_press_event) |=> !long_pending_reg)
        else $error("long press fired but remains pending");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for button_debounce_long_press.
// Holds an event scoreboard with its own debounce predictor, plus drivers and monitors.
// Depends on bdlp_pkg and the RTL top level.

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bdlp_pkg::*;

    // Run limit in clock cycles. A correct run sends about 1.5k samples. Even if
    // every sample met the longest input gap and the longest output stall, the run
    // would still stay well inside the limit.
    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int unsigned PHASE_BEATS = 140;     // minimum random samples per random phase

    // Scoreboard: predicts the event flags for every accepted pin sample and
    // checks each result beat against the oldest prediction.
    class press_event_board;
        logic [CNT_W-1:0] debounce_lim;
        logic [CNT_W-1:0] long_lim;
        logic             last_raw;
        logic             stable_lvl;
        logic             long_armed;
        logic [CNT_W-1:0] stable_cnt;
        logic [CNT_W-1:0] hold_cnt;
        result_t          flags_due[$];
        int               errors;

        function new();
            debounce_lim = DEBOUNCE_RESET;
            long_lim     = LONG_PRESS_RESET;
            last_raw     = LVL_RELEASED;
            stable_lvl   = LVL_RELEASED;
            long_armed   = 1'b0;
            stable_cnt   = '0;
            hold_cnt     = '0;
            errors       = 0;
        endfunction

        function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
            return (&v) ? v : v + 1'b1;
        endfunction

        function void set_limit(input cfg_idx_t idx, input logic [CNT_W-1:0] v);
            if (idx == REG_DEBOUNCE_LIMIT)
                debounce_lim = v;
            else
                long_lim = v;
        endfunction

        function void note_sample(input logic pin);
            result_t r;
            r = '0;
            // time keeps running, even on a restart tick
            hold_cnt = bump(hold_cnt);
            if (pin != last_raw)
            begin
                // raw change: restart debounce, no events this tick
                stable_cnt = '0;
                last_raw   = pin;
            end
            else
            begin
                stable_cnt = bump(stable_cnt);
                if (stable_cnt > debounce_lim && pin != stable_lvl)
                begin
                    stable_lvl = pin;
                    if (stable_lvl == LVL_RELEASED)
                    begin
                        r.short_press_event = long_armed;
                        r.release_event     = 1'b1;
                        long_armed          = 1'b0;
                    end
                    else
                    begin
                        long_armed = 1'b1;
                        hold_cnt   = '0;
                    end
                end
                if (long_armed && hold_cnt > long_lim)
                begin
                    long_armed         = 1'b0;
                    r.long_press_event = 1'b1;
                end
                r.held_flag = (stable_lvl == LVL_PRESSED);
            end
            flags_due = {flags_due, r};
        endfunction

        function void check_flags(input result_t got);
            result_t want;
            string   names[4];
            names = '{"short_press_event", "release_event", "long_press_event", "held_flag"};
            if (flags_due.size() == 0)
            begin
                $error("result beat with no sample pending");
                errors++;
                return;
            end
            want = flags_due.pop_front();
            // struct bits run msb first in the order of names
            for (int i = 0; i < 4; i++)
                if (want[3-i] !== got[3-i])
                begin
                    $error("%s: expected %0b, actual %0b", names[i], want[3-i], got[3-i]);
                    errors++;
                end
        endfunction

        function int pending();
            return flags_due.size();
        endfunction
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    cfg_idx_t         cfg_index = REG_DEBOUNCE_LIMIT;
    logic [CNT_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    logic             pin_level = LVL_RELEASED;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic             short_press_event;
    logic             release_event;
    logic             long_press_event;
    logic             held_flag;

    press_event_board board = new();

    bit          gaps_on;      // input-side idling enabled for the current run
    int          cur_db;       // limits in force, for sizing the stimulus
    int          cur_lp;
    int unsigned cycles;
    int unsigned beats_sent;   // samples taken by the block so far

    always #1 clk = ~clk;

    button_debounce_long_press DUT
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .pin_level         (pin_level),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .short_press_event (short_press_event),
        .release_event     (release_event),
        .long_press_event  (long_press_event),
        .held_flag         (held_flag)
    );

    // Monitor. All handshake signals are read as they stood just before the edge.
    // Drivers only use nonblocking updates, so this is race free. The result is
    // checked before the sample is noted, since a sample's own flags can't leave
    // on the edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                board.set_limit(cfg_index, cfg_data);
            if (out_valid && !out_stall)
                board.check_flags('{short_press_event, release_event,
                                    long_press_event, held_flag});
            if (in_valid && !in_stall)
                board.note_sample(pin_level);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Input gap: mostly back to back, sometimes short, rarely long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Output back-pressure: alternate stall runs and free runs.
    // Stall runs are short with an occasional long one. Free runs are sometimes
    // long, so the block also sees stretches at full rate.
    initial
    begin
        int run;
        bit stalled;
        run     = 0;
        stalled = 1'b0;
        forever
        begin
            @(posedge clk);
            if (run > 0)
                run--;
            else
            begin
                int r;
                r       = $urandom_range(0, 99);
                stalled = !stalled;
                if (stalled)
                    run = (r < 70) ? $urandom_range(1, 3) :
                          (r < 95) ? $urandom_range(4, 12) : $urandom_range(20, 80);
                else
                    run = (r < 80) ? $urandom_range(1, 10) : $urandom_range(30, 150);
                out_stall <= stalled;
            end
        end
    end

    // One pin sample, held until the block takes it.
    task automatic send_sample(input logic pin);
        int gap;
        gap = gaps_on ? idle_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        pin_level <= pin;
        do @(posedge clk); while (in_stall);
        beats_sent++;
    endtask

    task automatic drive_run(input logic pin, input int n);
        repeat (n) send_sample(pin);
    endtask

    // Contact bounce that settles on the given level.
    task automatic bounce(input logic settle_lvl, input int dbc);
        repeat ($urandom_range(0, 3))
        begin
            drive_run(!settle_lvl, $urandom_range(1, 2));
            drive_run(settle_lvl, $urandom_range(1, (dbc > 0) ? dbc : 1));
        end
    endtask

    // Wait until every predicted beat has come back, then let the pipe go quiet.
    // The first edge lets the monitor note the last sample before pending is read.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Both limits are written back to back while the block is idle.
    task automatic set_limits(input logic [CNT_W-1:0] db, input logic [CNT_W-1:0] lp);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEBOUNCE_LIMIT;
        cfg_data  <= db;
        @(posedge clk);
        cfg_index <= REG_LONG_PRESS_LIMIT;
        cfg_data  <= lp;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_db = int'(db);
        cur_lp = int'(lp);
    endtask

    // Random phase, mostly well formed presses with bounce, some presses too short
    // to pass the debounce, and some raw noise. Lengths are capped so that the
    // huge-limit phase stays short.
    task automatic random_phase(input logic [CNT_W-1:0] db, input logic [CNT_W-1:0] lp);
        int          dbc;
        int          lpc;
        int unsigned start;
        set_limits(db, lp);
        dbc   = (cur_db > 20) ? 20 : cur_db;
        lpc   = (cur_lp > 40) ? 40 : cur_lp;
        start = beats_sent;
        while (beats_sent - start < PHASE_BEATS)
        begin
            int r;
            r       = $urandom_range(0, 99);
            gaps_on = ($urandom_range(0, 9) < 7);
            if (r < 75)
            begin
                bounce(LVL_PRESSED, dbc);
                drive_run(LVL_PRESSED, $urandom_range(dbc + 1, dbc + lpc + 6));
                bounce(LVL_RELEASED, dbc);
                drive_run(LVL_RELEASED, $urandom_range(dbc + 1, dbc + 4));
            end
            else if (r < 90)
            begin
                drive_run(LVL_PRESSED, $urandom_range(1, dbc + 1));
                drive_run(LVL_RELEASED, $urandom_range(1, dbc + 2));
            end
            else
                repeat ($urandom_range(1, 8)) send_sample(1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        cycles     = 0;
        beats_sent = 0;
        gaps_on    = 1'b1;
        cur_db     = int'(DEBOUNCE_RESET);
        cur_lp     = int'(LONG_PRESS_RESET);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset limits: a press held past the debounce but short of a long press,
        // so the release brings a short press.
        drive_run(LVL_PRESSED, 70);
        drive_run(LVL_RELEASED, 70);

        // Directed, debounce 1 and long press 2. A restart, then bounce and a hold
        // long enough for a long press, then the release (no short press). After
        // that a press released before the long press (short press).
        set_limits(16'd1, 16'd2);
        drive_run(LVL_PRESSED, 1);
        drive_run(LVL_RELEASED, 1);
        drive_run(LVL_PRESSED, 6);
        drive_run(LVL_RELEASED, 4);
        drive_run(LVL_PRESSED, 3);
        drive_run(LVL_RELEASED, 3);

        // Both limits zero. The long press can't fire on the tick that accepts
        // the press, only on the one after.
        set_limits(16'd0, 16'd0);
        drive_run(LVL_PRESSED, 3);
        drive_run(LVL_RELEASED, 2);

        random_phase(16'd0, 16'd0);
        random_phase(16'd1, 16'd5);
        random_phase(16'd3, 16'd12);
        random_phase(16'd6, 16'd30);
        random_phase(16'd2, 16'd0);
        random_phase(16'd0, 16'd40);
        random_phase(16'hFFFF, 16'hFFFF);
        random_phase(16'd4, 16'd8);

        settle();
        repeat (8) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
